FILE: hdl/ab6_pkg.sv
// ----------------------------------------------------------------------------
// ab6_pkg
// Types and constants shared by the six-step Adams-Bashforth step unit.
// ----------------------------------------------------------------------------
package ab6_pkg;

  localparam int SLOTS     = 5;
  localparam int NCOEF     = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_LOAD_STATE = 2'd0;
  localparam logic [1:0] OP_LOAD_HIST  = 2'd1;
  localparam logic [1:0] OP_STEP       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 3'd6;

  localparam logic [NCOEF-1:0][31:0] COEF_RESET = '{
    32'hFFAB8E46, 32'd33519480, 32'hFAEE8BE9,
    32'd116298748, 32'hFA7F7178, 32'd49830659
  };
  localparam logic [30:0] STEP_RESET = 31'd167772;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         element_index;
    logic [2:0]         history_slot;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_index;
    logic signed [31:0] state_x;
    logic signed [31:0] state_y;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] res;
    logic               sat;
  } lane_res_t;

endpackage

FILE: hdl/ab6_lane.sv
// ----------------------------------------------------------------------------
// ab6_lane
// One vector component: weighted derivative sum, scale by h, round, add, clamp.
// ----------------------------------------------------------------------------
module ab6_lane (
  input  logic                   clk,
  input  logic [5:0][31:0]       coef,
  input  logic [30:0]            step,
  input  logic [5:0][31:0]       deriv,
  input  logic signed [31:0]     state,
  output ab6_pkg::lane_res_t     res
);
  import ab6_pkg::*;

  logic signed [63:0] prod_r [NCOEF];
  logic signed [64:0] pair_r [3];
  logic signed [66:0] sum_r;
  logic [66:0]        mag_r;
  logic [62:0]        t0_r;
  logic [62:0]        t1_r;
  logic [33:0]        t2_r;
  logic [49:0]        inc_r;
  logic               neg5_r, neg6_r, neg7_r;
  logic signed [31:0] st_r [6];
  logic [97:0]        acc;
  logic signed [51:0] upd;
  lane_res_t          res_nxt;
  lane_res_t          res_r;

  // product of magnitude and h, rounded at bit 47, gives the Q16.16 increment
  assign acc = 98'(t0_r) + (98'(t1_r) << 32) + (98'(t2_r) << 64) + (98'(1) << 47);

  always_comb begin
    upd = neg7_r ? (52'(st_r[5]) - $signed({2'b00, inc_r}))
                 : (52'(st_r[5]) + $signed({2'b00, inc_r}));
    res_nxt.res = 32'(upd);
    res_nxt.sat = 1'b0;
    if (upd > 52'sd2147483647) begin
      res_nxt.res = 32'sh7FFFFFFF;
      res_nxt.sat = 1'b1;
    end else if (upd < -52'sd2147483648) begin
      res_nxt.res = 32'sh80000000;
      res_nxt.sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NCOEF; k++) begin
      prod_r[k] <= $signed(coef[k]) * $signed(deriv[k]);
    end
    pair_r[0] <= 65'(prod_r[0]) + 65'(prod_r[1]);
    pair_r[1] <= 65'(prod_r[2]) + 65'(prod_r[3]);
    pair_r[2] <= 65'(prod_r[4]) + 65'(prod_r[5]);
    sum_r     <= 67'(pair_r[0]) + 67'(pair_r[1]) + 67'(pair_r[2]);
    neg5_r    <= sum_r[66];
    mag_r     <= sum_r[66] ? 67'(-sum_r) : 67'(sum_r);
    neg6_r    <= neg5_r;
    t0_r      <= 63'(mag_r[31:0]) * 63'(step);
    t1_r      <= 63'(mag_r[63:32]) * 63'(step);
    t2_r      <= 34'(mag_r[66:64]) * 34'(step);
    neg7_r    <= neg6_r;
    inc_r     <= acc[97:48];
    st_r[0]   <= state;
    for (int i = 1; i < 6; i++) begin
      st_r[i] <= st_r[i-1];
    end
    res_r     <= res_nxt;
  end

  assign res = res_r;

endmodule

FILE: hdl/ab6_merge.sv
// ----------------------------------------------------------------------------
// ab6_merge
// Joins the two lane results into one result beat.
// ----------------------------------------------------------------------------
module ab6_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld,
  input  logic [7:0]          index,
  input  ab6_pkg::lane_res_t  res_x,
  input  ab6_pkg::lane_res_t  res_y,
  output logic                out_valid,
  output ab6_pkg::out_item_t  out_data
);
  import ab6_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld;
    end
    data_r.out_index <= index;
    data_r.state_x   <= res_x.res;
    data_r.state_y   <= res_y.res;
    data_r.saturated <= res_x.sat | res_y.sat;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: hdl/adams_bashforth6_step_unit.sv
// ----------------------------------------------------------------------------
// adams_bashforth6_step_unit
// A step beat passes the stage-1 registers, the lane pipeline and the merge register before its result strobe.
// Throughput: one beat per cycle; busy holds a beat whose element is still in the
// 8-stage update pipeline, or a state load that would meet a write-back.
// Reset clears control and config registers; state and history memories are not cleared.
// The receiver cannot stall: out_valid lasts exactly one cycle.
// ----------------------------------------------------------------------------
module adams_bashforth6_step_unit #(
  parameter int ELEMENTS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ab6_pkg::in_item_t   in_data,
  output logic                out_valid,
  output ab6_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import ab6_pkg::*;

  localparam int AW     = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int STAGES = 8;

  typedef struct packed {
    logic          vld;
    logic          step;
    logic [AW-1:0] addr;
  } ctl_t;

  logic [NCOEF-1:0][31:0] coef_r;
  logic [30:0]            step_r;

  ctl_t          ctl_r [1:STAGES];
  ctl_t          ctl_nxt;
  logic [1:0]    r1_op_r;
  logic [2:0]    r1_slot_r;
  logic [63:0]   r1_val_r;
  logic [AW-1:0] in_addr;
  logic          in_range;
  logic          accept;
  logic          hazard;

  logic [63:0]   state_mem [ELEMENTS];
  logic [63:0]   state_rd_r;
  logic [63:0]   hist_rd [SLOTS];
  logic [5:0][31:0] deriv_x, deriv_y;
  lane_res_t     res_x, res_y;

  assign in_addr  = AW'(in_data.element_index);
  assign in_range = 32'(in_data.element_index) < ELEMENTS;
  assign accept   = start & ~busy;

  always_comb begin
    hazard = 1'b0;
    for (int s = 1; s <= STAGES; s++) begin
      if (ctl_r[s].vld && (s == 1 || ctl_r[s].step) && ctl_r[s].addr == in_addr) begin
        hazard = 1'b1;
      end
    end
    // state load would share the write port with a finishing step
    if (in_data.operation == OP_LOAD_STATE && ctl_r[STAGES-1].vld && ctl_r[STAGES-1].step) begin
      hazard = 1'b1;
    end
  end
  assign busy = hazard;

  always_comb begin
    ctl_nxt.addr = in_addr;
    ctl_nxt.step = in_data.operation == OP_STEP;
    ctl_nxt.vld  = 1'b0;
    if (accept && in_range) begin
      case (in_data.operation)
        OP_LOAD_STATE, OP_STEP: ctl_nxt.vld = 1'b1;
        OP_LOAD_HIST:           ctl_nxt.vld = in_data.history_slot < 3'(SLOTS);
        default:                ctl_nxt.vld = 1'b0;
      endcase
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_STEP_SIZE) begin
        step_r <= cfg_wdata[30:0];
      end else if (32'(cfg_index) < NCOEF) begin
        coef_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= STAGES; s++) begin
        ctl_r[s].vld <= 1'b0;
      end
    end else begin
      ctl_r[1].vld <= ctl_nxt.vld;
      for (int s = 2; s <= STAGES; s++) begin
        ctl_r[s].vld <= ctl_r[s-1].vld;
      end
    end
    ctl_r[1].step <= ctl_nxt.step;
    ctl_r[1].addr <= ctl_nxt.addr;
    for (int s = 2; s <= STAGES; s++) begin
      ctl_r[s].step <= ctl_r[s-1].step;
      ctl_r[s].addr <= ctl_r[s-1].addr;
    end
    r1_op_r   <= in_data.operation;
    r1_slot_r <= in_data.history_slot;
    r1_val_r  <= {in_data.value_y, in_data.value_x};
  end

  // state memory: read at accept, written by a state load or a finished step
  always_ff @(posedge clk) begin
    state_rd_r <= state_mem[in_addr];
    if (ctl_r[1].vld && r1_op_r == OP_LOAD_STATE) begin
      state_mem[ctl_r[1].addr] <= r1_val_r;
    end else if (ctl_r[STAGES].vld && ctl_r[STAGES].step) begin
      state_mem[ctl_r[STAGES].addr] <= {res_y.res, res_x.res};
    end
  end

  // history slots, one memory each; a step shifts the history from the stage-1 registers
  for (genvar k = 0; k < SLOTS; k++) begin : g_hist
    logic [63:0] mem [ELEMENTS];
    logic [63:0] rd_r;
    logic [63:0] wdata;
    logic        we;

    always_comb begin
      we    = 1'b0;
      wdata = r1_val_r;
      if (ctl_r[1].vld) begin
        if (r1_op_r == OP_LOAD_HIST && r1_slot_r == 3'(k)) begin
          we = 1'b1;
        end else if (r1_op_r == OP_STEP) begin
          we = 1'b1;
          if (k < SLOTS - 1) begin
            wdata = hist_rd[(k < SLOTS - 1) ? k + 1 : k];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      rd_r <= mem[in_addr];
      if (we) begin
        mem[ctl_r[1].addr] <= wdata;
      end
    end

    assign hist_rd[k] = rd_r;
  end

  always_comb begin
    deriv_x[0] = r1_val_r[31:0];
    deriv_y[0] = r1_val_r[63:32];
    for (int k = 1; k < NCOEF; k++) begin
      deriv_x[k] = hist_rd[SLOTS-k][31:0];
      deriv_y[k] = hist_rd[SLOTS-k][63:32];
    end
  end

  ab6_lane u_lane_x (
    .clk   (clk),
    .coef  (coef_r),
    .step  (step_r),
    .deriv (deriv_x),
    .state (state_rd_r[31:0]),
    .res   (res_x)
  );

  ab6_lane u_lane_y (
    .clk   (clk),
    .coef  (coef_r),
    .step  (step_r),
    .deriv (deriv_y),
    .state (state_rd_r[63:32]),
    .res   (res_y)
  );

  ab6_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld       (ctl_r[STAGES].vld & ctl_r[STAGES].step),
    .index     (8'(ctl_r[STAGES].addr)),
    .res_x     (res_x),
    .res_y     (res_y),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
